/* rtl/mi3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ENTRIES  = 9;
	localparam int CMAG_W   = 32;   // cofactor magnitude, 16 fraction bits
	localparam int DMAG_W   = 48;   // determinant magnitude, 24 fraction bits
	localparam int QUO_W    = 32;   // quotient bits kept per lane
	localparam int FRONT_LAT = 4;   // cofactor / determinant stages
	localparam int LANE_LAT  = 33;  // operand setup plus one stage per quotient bit

	// input word: one matrix, signed Q8.8 entries
	typedef struct packed {
		logic signed [15:0] a00;
		logic signed [15:0] a01;
		logic signed [15:0] a02;
		logic signed [15:0] a10;
		logic signed [15:0] a11;
		logic signed [15:0] a12;
		logic signed [15:0] a20;
		logic signed [15:0] a21;
		logic signed [15:0] a22;
	} mat_t;

	// output word: inverse in signed Q16.16 plus status
	typedef struct packed {
		logic signed [31:0] inv00;
		logic signed [31:0] inv01;
		logic signed [31:0] inv02;
		logic signed [31:0] inv10;
		logic signed [31:0] inv11;
		logic signed [31:0] inv12;
		logic signed [31:0] inv20;
		logic signed [31:0] inv21;
		logic signed [31:0] inv22;
		logic               singular;
		logic               overflow;
	} inv_t;

endpackage
`default_nettype wire

/* rtl/matrix_inverse_3x3.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a 3x3 signed Q8.8 matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
// One matrix word is taken per cycle and one inverse word leaves per cycle
// unless the output is stalled. Four cofactor/determinant stages, nine
// divider lanes of 33 stages (one quotient bit per stage sets the depth)
// and one output register make up the path. Entries are rounded to nearest
// (ties away from zero) and saturated to Q16.16, raising overflow. A zero
// determinant gives singular and all-zero entries. The whole pipeline holds
// while an output word is stalled; input stall follows that hold.
module matrix_inverse_3x3 (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          mat_valid,
	output logic               mat_stall,
	input  wire mi3_pkg::mat_t mat,
	output logic               inv_valid,
	input  wire logic          inv_stall,
	output mi3_pkg::inv_t      inv
);

	localparam int LAT = mi3_pkg::FRONT_LAT + mi3_pkg::LANE_LAT;

	logic adv;
	logic vld_q [0:LAT-1];
	logic out_valid_q;
	logic sing_q [0:mi3_pkg::LANE_LAT-1];

	logic [mi3_pkg::CMAG_W-1:0] cmag [0:8];
	logic                       cneg [0:8];
	logic [mi3_pkg::DMAG_W-1:0] dmag;
	logic                       sing;
	logic [mi3_pkg::QUO_W-1:0]  quo  [0:8];
	logic                       big  [0:8];
	logic                       qneg [0:8];

	// pipeline moves unless the output word is held
	assign adv       = !(out_valid_q && inv_stall);
	assign mat_stall = !adv;
	assign inv_valid = out_valid_q;

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++)
				vld_q[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= mat_valid;
			for (int k = 1; k < LAT; k++)
				vld_q[k] <= vld_q[k-1];
			out_valid_q <= vld_q[LAT-1];
		end
	end

	// singular flag rides alongside the divider lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			sing_q[0] <= sing;
			for (int k = 1; k < mi3_pkg::LANE_LAT; k++)
				sing_q[k] <= sing_q[k-1];
		end
	end

	mi3_front u_front (
		.clk  (clk),
		.en   (adv),
		.mat  (mat),
		.cmag (cmag),
		.neg  (cneg),
		.dmag (dmag),
		.sing (sing)
	);

	// entry [i][j] divides cofactor [j][i]
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			mi3_div_lane u_lane (
				.clk     (clk),
				.en      (adv),
				.cmag    (cmag[j*3+i]),
				.dmag    (dmag),
				.neg     (cneg[j*3+i]),
				.quo     (quo[i*3+j]),
				.big     (big[i*3+j]),
				.quo_neg (qneg[i*3+j])
			);
		end
	end

	mi3_merge u_merge (
		.clk  (clk),
		.en   (adv),
		.quo  (quo),
		.big  (big),
		.neg  (qneg),
		.sing (sing_q[mi3_pkg::LANE_LAT-1]),
		.res  (inv)
	);

endmodule
`default_nettype wire

/* rtl/mi3_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_front
// Signed cofactors and determinant (first-row expansion), four stages.
// Hands out cofactor magnitudes, result signs and determinant magnitude.
// ----------------------------------------------------------------------------
module mi3_front (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire mi3_pkg::mat_t                mat,
	output logic [mi3_pkg::CMAG_W-1:0]        cmag [0:8],
	output logic                              neg  [0:8],
	output logic [mi3_pkg::DMAG_W-1:0]        dmag,
	output logic                              sing
);

	logic signed [15:0] l0 [0:8];
	logic signed [15:0] r0 [0:8];
	logic signed [15:0] l1 [0:8];
	logic signed [15:0] r1 [0:8];

	logic signed [31:0] p0_s1 [0:8];
	logic signed [31:0] p1_s1 [0:8];
	logic signed [15:0] a0_s1 [0:2];
	logic signed [32:0] cof_s2 [0:8];
	logic signed [15:0] a0_s2 [0:2];
	logic signed [48:0] dp_s3 [0:2];
	logic [mi3_pkg::CMAG_W-1:0] cmag_s3 [0:8];
	logic                       cneg_s3 [0:8];
	logic [mi3_pkg::CMAG_W-1:0] cmag_s4 [0:8];
	logic                       neg_s4  [0:8];
	logic [mi3_pkg::DMAG_W-1:0] dmag_s4;
	logic                       sing_s4;

	logic signed [50:0] det;
	logic [50:0]        det_abs;

	// minor operand pairs: minor = l0*r0 - l1*r1
	always_comb begin
		l0[0] = mat.a11; r0[0] = mat.a22; l1[0] = mat.a21; r1[0] = mat.a12;
		l0[1] = mat.a10; r0[1] = mat.a22; l1[1] = mat.a20; r1[1] = mat.a12;
		l0[2] = mat.a10; r0[2] = mat.a21; l1[2] = mat.a20; r1[2] = mat.a11;
		l0[3] = mat.a01; r0[3] = mat.a22; l1[3] = mat.a21; r1[3] = mat.a02;
		l0[4] = mat.a00; r0[4] = mat.a22; l1[4] = mat.a20; r1[4] = mat.a02;
		l0[5] = mat.a00; r0[5] = mat.a21; l1[5] = mat.a20; r1[5] = mat.a01;
		l0[6] = mat.a01; r0[6] = mat.a12; l1[6] = mat.a11; r1[6] = mat.a02;
		l0[7] = mat.a00; r0[7] = mat.a12; l1[7] = mat.a10; r1[7] = mat.a02;
		l0[8] = mat.a00; r0[8] = mat.a11; l1[8] = mat.a10; r1[8] = mat.a01;
	end

	// s1: products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				p0_s1[k] <= l0[k] * r0[k];
				p1_s1[k] <= l1[k] * r1[k];
			end
			a0_s1[0] <= mat.a00;
			a0_s1[1] <= mat.a01;
			a0_s1[2] <= mat.a02;
		end
	end

	// s2: cofactors with checkerboard sign
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				if ((k % 2) == 1)
					cof_s2[k] <= {p1_s1[k][31], p1_s1[k]} - {p0_s1[k][31], p0_s1[k]};
				else
					cof_s2[k] <= {p0_s1[k][31], p0_s1[k]} - {p1_s1[k][31], p1_s1[k]};
			end
			a0_s2 <= a0_s1;
		end
	end

	// s3: determinant terms, cofactor magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				dp_s3[j] <= 49'(a0_s2[j]) * 49'(cof_s2[j]);
			for (int k = 0; k < 9; k++) begin
				cneg_s3[k] <= cof_s2[k][32];
				cmag_s3[k] <= cof_s2[k][32] ? 32'(-cof_s2[k]) : cof_s2[k][31:0];
			end
		end
	end

	// s4: determinant sum, signs of the quotients
	always_comb begin
		det = 51'(dp_s3[0]) + 51'(dp_s3[1]) + 51'(dp_s3[2]);
		det_abs = det[50] ? 51'(-det) : 51'(det);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				neg_s4[k] <= cneg_s3[k] ^ det[50];
			end
			cmag_s4 <= cmag_s3;
			dmag_s4 <= det_abs[mi3_pkg::DMAG_W-1:0];
			sing_s4 <= (det == '0);
		end
	end

	assign cmag = cmag_s4;
	assign neg  = neg_s4;
	assign dmag = dmag_s4;
	assign sing = sing_s4;

endmodule
`default_nettype wire

/* rtl/mi3_div_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider, one quotient bit per stage.
// Computes round(cmag * 2^24 / dmag) as floor((2N + D) / 2D); flags
// quotients of 2^32 or more as big.
// ----------------------------------------------------------------------------
module mi3_div_lane (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [mi3_pkg::CMAG_W-1:0]    cmag,
	input  wire logic [mi3_pkg::DMAG_W-1:0]    dmag,
	input  wire logic                          neg,
	output logic [mi3_pkg::QUO_W-1:0]          quo,
	output logic                               big,
	output logic                               quo_neg
);

	localparam int NW = mi3_pkg::CMAG_W + 26;     // numerator 2N + D
	localparam int DW = mi3_pkg::DMAG_W + 1;      // divisor 2D
	localparam int QW = mi3_pkg::QUO_W;

	logic [NW-1:0] num_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] q_s   [0:QW];
	logic          neg_s [0:QW];
	logic          big_s [0:QW];

	logic [NW-1:0] nsum;

	// operand setup
	assign nsum = {1'b0, cmag, 25'b0} + NW'(dmag);

	// quotient reaches 2^32 when the upper numerator bits already cover 2D
	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= nsum;
			den_s[0] <= {dmag, 1'b0};
			rem_s[0] <= DW'(nsum[NW-1:QW]);
			q_s[0]   <= '0;
			neg_s[0] <= neg;
			big_s[0] <= (DW'(nsum[NW-1:QW]) >= {dmag, 1'b0});
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar t = 1; t <= QW; t++) begin : g_step
		logic [DW:0] rt;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			rt   = {rem_s[t-1], num_s[t-1][QW-t]};
			diff = rt - {1'b0, den_s[t-1]};
			ge   = (rt >= {1'b0, den_s[t-1]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[t] <= num_s[t-1];
				den_s[t] <= den_s[t-1];
				rem_s[t] <= ge ? diff[DW-1:0] : rt[DW-1:0];
				q_s[t]   <= {q_s[t-1][QW-2:0], ge};
				neg_s[t] <= neg_s[t-1];
				big_s[t] <= big_s[t-1];
			end
		end
	end

	assign quo     = q_s[QW];
	assign big     = big_s[QW];
	assign quo_neg = neg_s[QW];

endmodule
`default_nettype wire

/* rtl/mi3_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_merge
// Applies sign and Q16.16 saturation to the nine lane quotients, ORs the
// overflow flags and registers the output word.
// ----------------------------------------------------------------------------
module mi3_merge (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [mi3_pkg::QUO_W-1:0]     quo  [0:8],
	input  wire logic                          big  [0:8],
	input  wire logic                          neg  [0:8],
	input  wire logic                          sing,
	output mi3_pkg::inv_t                      res
);

	logic [31:0]   ent [0:8];
	logic          sat [0:8];
	logic          ovf;
	mi3_pkg::inv_t res_q;

	// per-entry sign and clamp
	always_comb begin
		ovf = 1'b0;
		for (int k = 0; k < 9; k++) begin
			sat[k] = 1'b0;
			if (sing || (!big[k] && quo[k] == '0)) begin
				ent[k] = '0;
			end else if (neg[k]) begin
				if (big[k] || quo[k] > 32'h8000_0000) begin
					ent[k] = 32'h8000_0000;
					sat[k] = 1'b1;
				end else begin
					ent[k] = -quo[k];
				end
			end else begin
				if (big[k] || quo[k][31]) begin
					ent[k] = 32'h7FFF_FFFF;
					sat[k] = 1'b1;
				end else begin
					ent[k] = quo[k];
				end
			end
			ovf = ovf | sat[k];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			res_q.inv00    <= ent[0];
			res_q.inv01    <= ent[1];
			res_q.inv02    <= ent[2];
			res_q.inv10    <= ent[3];
			res_q.inv11    <= ent[4];
			res_q.inv12    <= ent[5];
			res_q.inv20    <= ent[6];
			res_q.inv21    <= ent[7];
			res_q.inv22    <= ent[8];
			res_q.singular <= sing;
			res_q.overflow <= ovf;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

/* tb/tb_matrix_inverse_3x3.sv */
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3
// Self-checking bench for the 3x3 fixed-point matrix inverse pipeline.
// ----------------------------------------------------------------------------
// Matrix words are sent in random bursts. The receiving side stalls on its own
// pattern, with one long hold-off that backs the pipeline up. Each inverse
// word is checked field by field against a behavioral inverse model kept
// in the bench. A directed table comes first, then random matrices.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_3x3;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_DEPTH = 38;
	localparam int RAND_WORDS = 1250;
	localparam longint CYCLE_LIMIT = 400000;

	localparam logic [31:0] Q_MAX = 32'h7FFFFFFF;
	localparam logic [31:0] Q_MIN = 32'h80000000;

	logic clk;
	logic arst_n;
	logic mat_valid;
	logic mat_stall;
	mi3_pkg::mat_t mat;
	logic inv_valid;
	logic inv_stall;
	mi3_pkg::inv_t inv;

	mi3_pkg::inv_t pending_inverses[$];
	int errors = 0;
	longint cycles = 0;
	bit long_hold_req = 0;
	bit long_hold_done = 0;

	matrix_inverse_3x3 DUT (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
		.inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// rounded, saturated Q16.16 quotient of one cofactor over the determinant
	function automatic logic [32:0] divide_entry(longint c, longint d);
		logic [63:0] cmag;
		logic [63:0] dmag;
		logic [63:0] q;
		bit neg;
		neg = (c < 0) != (d < 0);
		cmag = (c < 0) ? -c : c;
		dmag = (d < 0) ? -d : d;
		q = ((cmag << 25) + dmag) / (2 * dmag);
		if (q == 0) return 33'd0;
		if (neg) begin
			if (q > 64'h80000000) return {1'b1, Q_MIN};
			return {1'b0, 32'(-q)};
		end
		if (q > 64'h7FFFFFFF) return {1'b1, Q_MAX};
		return {1'b0, q[31:0]};
	endfunction

	function automatic mi3_pkg::inv_t invert_matrix(mi3_pkg::mat_t m);
		longint a[3][3];
		longint cof[3][3];
		longint det;
		logic [32:0] e;
		logic [31:0] res[9];
		mi3_pkg::inv_t r;
		bit ovf;
		int rr[2];
		int cc[2];
		int g;
		int h;
		a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
		a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
		a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				g = 0; h = 0;
				for (int k = 0; k < 3; k++) begin
					if (k != i) begin rr[g] = k; g++; end
					if (k != j) begin cc[h] = k; h++; end
				end
				cof[i][j] = a[rr[0]][cc[0]] * a[rr[1]][cc[1]]
					- a[rr[1]][cc[0]] * a[rr[0]][cc[1]];
				if ((i + j) % 2) cof[i][j] = -cof[i][j];
			end
		det = 0;
		for (int i = 0; i < 3; i++) begin
			det += a[0][i] * a[1][(i + 1) % 3] * a[2][(i + 2) % 3];
			det -= a[0][i] * a[1][(i + 2) % 3] * a[2][(i + 1) % 3];
		end
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		ovf = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				e = divide_entry(cof[j][i], det);
				ovf |= e[32];
				res[i * 3 + j] = e[31:0];
			end
		r.inv00 = res[0]; r.inv01 = res[1]; r.inv02 = res[2];
		r.inv10 = res[3]; r.inv11 = res[4]; r.inv12 = res[5];
		r.inv20 = res[6]; r.inv21 = res[7]; r.inv22 = res[8];
		r.overflow = ovf;
		return r;
	endfunction

	function automatic logic [15:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return 16'($signed($urandom_range(0, 1536)) - 768);
			1: return 16'(16'h0100 * $urandom_range(0, 3));
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			3: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic mi3_pkg::mat_t rand_matrix();
		mi3_pkg::mat_t m;
		m.a00 = rand_entry(); m.a01 = rand_entry(); m.a02 = rand_entry();
		m.a10 = rand_entry(); m.a11 = rand_entry(); m.a12 = rand_entry();
		m.a20 = rand_entry(); m.a21 = rand_entry(); m.a22 = rand_entry();
		// occasionally force a singular matrix: copy row 0 into row 2
		if ($urandom_range(0, 15) == 0) begin
			m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
		end
		return m;
	endfunction

	// offer one word and hold it until accepted
	task automatic send_matrix(mi3_pkg::mat_t m);
		mat <= m;
		mat_valid <= 1'b1;
		do @(posedge clk); while (mat_stall);
		pending_inverses.push_back(invert_matrix(m));
	endtask

	// called at a falling edge: drop valid right away, then let the sender idle
	task automatic idle_sender(int n);
		mat_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// directed table: entries plus a typed-in result where obvious
	typedef struct {
		mi3_pkg::mat_t m;
		bit known;
		mi3_pkg::inv_t r;
	} mat_case_t;

	function automatic mat_case_t mk(mi3_pkg::mat_t m);
		mat_case_t c;
		c.m = m; c.known = 0; c.r = '0;
		return c;
	endfunction

	function automatic mat_case_t mk_known(mi3_pkg::mat_t m, mi3_pkg::inv_t r);
		mat_case_t c;
		c.m = m; c.known = 1; c.r = r;
		return c;
	endfunction

	mat_case_t directed[$];

	initial begin
		mi3_pkg::inv_t zero_sing;
		mi3_pkg::inv_t ident;
		zero_sing = '0; zero_sing.singular = 1'b1;
		ident = '0;
		ident.inv00 = 32'h00010000; ident.inv11 = 32'h00010000; ident.inv22 = 32'h00010000;
		// all zero: singular
		directed.push_back(mk_known('0, zero_sing));
		// identity
		directed.push_back(mk_known('{16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100}, ident));
		// all ones: singular
		directed.push_back(mk_known({9{16'hFFFF}}, zero_sing));
		directed.push_back(mk_known({9{16'h7FFF}}, zero_sing));
		directed.push_back(mk_known({9{16'h8000}}, zero_sing));
		// smallest diagonal: inverse entries of 256.0, within range
		directed.push_back(mk('{16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001}));
		// negative smallest diagonal: inverse entries of -256.0, within range
		directed.push_back(mk('{16'hFFFF, 0, 0, 0, 16'hFFFF, 0, 0, 0, 16'hFFFF}));
		directed.push_back(mk('{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000}));
		directed.push_back(mk('{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF}));
		directed.push_back(mk('{16'h7FFF, 16'h8000, 0, 0, 16'h7FFF, 16'h8000,
			16'h8000, 0, 16'h7FFF}));
		// permutation matrix: negative determinant
		directed.push_back(mk('{0, 16'h0100, 0, 16'h0100, 0, 0, 0, 0, 16'h0100}));
		// inexact quotients needing rounding: diag 3
		directed.push_back(mk('{16'h0300, 0, 0, 0, 16'h0300, 0, 0, 0, 16'h0300}));
		directed.push_back(mk('{16'h0200, 16'h0100, 0, 16'h0100, 16'h0200, 16'h0100,
			0, 16'h0100, 16'h0200}));
		directed.push_back(mk('{16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, 16'h0F0F,
			16'hF0F0, 16'h00FF, 16'hFF00, 16'h8001}));
		directed.push_back(mk('{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005,
			16'h0006, 16'h0007, 16'h0008, 16'h000A}));
	end

	// drive: table, then random bursts with one drain pause
	initial begin
		mat_valid = 1'b0;
		mat = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[k]) begin
			send_matrix(directed[k].m);
			if (directed[k].known && pending_inverses[$] !== directed[k].r) begin
				$display("%0t directed row %0d: expected %h model %h", $time, k,
					directed[k].r, pending_inverses[$]);
				errors++;
			end
			@(negedge clk);
			if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 3));
		end
		// sender pause until every inverse is back
		mat_valid <= 1'b0;
		wait (pending_inverses.size() == 0);
		@(negedge clk);
		for (int n = 0; n < RAND_WORDS; ) begin
			int burst;
			burst = $urandom_range(1, 40);
			if (n >= RAND_WORDS / 3) long_hold_req = 1;
			for (int b = 0; b < burst && n < RAND_WORDS; b++, n++) begin
				send_matrix(rand_matrix());
				@(negedge clk);
			end
			if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 12));
		end
		mat_valid <= 1'b0;
		wait (pending_inverses.size() == 0);
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int mode;
		inv_stall = 1'b0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1;
				inv_stall <= 1'b1;
				for (int k = 0; k < 300; k++) @(negedge clk);
			end
			if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
			case (mode)
				0: inv_stall <= 1'b0;
				1: inv_stall <= ($urandom_range(0, 3) == 0);
				default: inv_stall <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	// check each accepted inverse word
	always @(posedge clk) begin
		if (arst_n && inv_valid && !inv_stall) begin
			if (pending_inverses.size() == 0) begin
				$display("%0t unexpected word: expected none actual %h", $time, inv);
				errors++;
			end else begin
				mi3_pkg::inv_t want;
				want = pending_inverses.pop_front();
				if (inv.inv00 !== want.inv00) begin $display("%0t inv00 exp %h act %h", $time, want.inv00, inv.inv00); errors++; end
				if (inv.inv01 !== want.inv01) begin $display("%0t inv01 exp %h act %h", $time, want.inv01, inv.inv01); errors++; end
				if (inv.inv02 !== want.inv02) begin $display("%0t inv02 exp %h act %h", $time, want.inv02, inv.inv02); errors++; end
				if (inv.inv10 !== want.inv10) begin $display("%0t inv10 exp %h act %h", $time, want.inv10, inv.inv10); errors++; end
				if (inv.inv11 !== want.inv11) begin $display("%0t inv11 exp %h act %h", $time, want.inv11, inv.inv11); errors++; end
				if (inv.inv12 !== want.inv12) begin $display("%0t inv12 exp %h act %h", $time, want.inv12, inv.inv12); errors++; end
				if (inv.inv20 !== want.inv20) begin $display("%0t inv20 exp %h act %h", $time, want.inv20, inv.inv20); errors++; end
				if (inv.inv21 !== want.inv21) begin $display("%0t inv21 exp %h act %h", $time, want.inv21, inv.inv21); errors++; end
				if (inv.inv22 !== want.inv22) begin $display("%0t inv22 exp %h act %h", $time, want.inv22, inv.inv22); errors++; end
				if (inv.singular !== want.singular) begin $display("%0t singular exp %b act %b", $time, want.singular, inv.singular); errors++; end
				if (inv.overflow !== want.overflow) begin $display("%0t overflow exp %b act %b", $time, want.overflow, inv.overflow); errors++; end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end
endmodule
